[sv/assert_macros.svh]
// Assertion macros used by the port-level checker of the adaptive filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define LMSF_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define LMSF_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lmsf_pkg.sv]
// Shared constants and widths of the LMS adaptive FIR filter.
package lmsf_pkg;

  localparam int TAPS_DEF = 32;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 24;
  localparam int STEP_W   = 16;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int MUERR_W  = STEP_W + ERR_W + 1;
  localparam int MULB_W   = SAMPLE_W + 1;
  localparam int PROD_W   = MUERR_W + MULB_W;
  localparam int MACP_W   = WEIGHT_W + SAMPLE_W;

  localparam int OUT_SHIFT = 20;
  localparam int UPD_SHIFT = 26;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;
  localparam int W_MAX   = 8388607;
  localparam int W_MIN   = -8388608;

endpackage

[sv/lmsf_if.sv]
// Handshake channel interfaces: sample pairs, filter results and step size writes.
interface lmsf_in_if import lmsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] primary_sample;
  logic signed [SAMPLE_W-1:0] reference_sample;

  modport source (output valid, output primary_sample, output reference_sample,
                  input ready);
  modport sink   (input valid, input primary_sample, input reference_sample,
                  output ready);
endinterface

interface lmsf_out_if import lmsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filter_output;

  modport source (output valid, output filter_output, input ready);
  modport sink   (input valid, input filter_output, output ready);
endinterface

interface lmsf_cfg_if import lmsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_size;

  modport source (output valid, output step_size, input ready);
  modport sink   (input valid, input step_size, output ready);
endinterface

[sv/lmsf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lmsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lms_adaptive_fir_unit.sv]
// Top level of the LMS adaptive FIR filter with a shared multiply unit.
//
// Usage. The samples channel carries one beat per item: a primary sample and a
// reference sample, both signed Q1.15. The result channel returns one beat per
// item, the saturated FIR output in Q1.15, computed with the weights as they
// stood before that item. The cfg channel writes the unsigned Q0.16 step size;
// it is always ready and should only be written while the block is idle.
//
// Timing. One multiplier does all the work, one product per cycle: a pass over
// the taps for the dot product, one product for step size times error, and a
// second pass over the taps for the weight update. An item therefore occupies
// the block through both passes and its done state; the result beat becomes
// valid as the block returns to idle. samples.ready is high only while idle.
//
// Reset. After rst the step size returns to its reset value and a clearing
// pass over all TAPS addresses zeroes the delay line and weight memories;
// samples.ready stays low during that pass.
//
// Stalls. The result sits in an output register. The next input beat is taken
// while it waits; if the following result is done before the old one is taken,
// the block holds in its final state until the receiver takes the old beat.
module lms_adaptive_fir_unit import lmsf_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lmsf_in_if.sink    samples,
  lmsf_out_if.source result,
  lmsf_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int ACC_W = MACP_W + IDX_W;
  localparam int SH_W  = ACC_W - OUT_SHIFT;
  localparam int D_W   = PROD_W - UPD_SHIFT;
  localparam int WS_W  = WEIGHT_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MAC, ST_ROUND, ST_MUERR, ST_MULAT, ST_UPD, ST_DONE
  } state_t;

  state_t state;

  // Control and configuration registers.
  logic [STEP_W-1:0]          step_reg;
  logic [IDX_W-1:0]           clr_cnt;
  logic [IDX_W-1:0]           head;
  logic [IDX_W-1:0]           dly_addr;
  logic [CNT_W-1:0]           issue_cnt;
  logic                       s1_vld;
  logic                       s2_vld;
  logic                       out_vld;
  logic signed [SAMPLE_W-1:0] out_data;

  // Datapath registers.
  logic signed [SAMPLE_W-1:0] primary;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] y_reg;
  logic signed [ERR_W-1:0]    err_reg;
  logic signed [MUERR_W-1:0]  mu_err;
  logic signed [PROD_W-1:0]   product;
  logic [IDX_W-1:0]           s1_widx;
  logic [IDX_W-1:0]           s2_widx;
  logic signed [WEIGHT_W-1:0] s2_w;

  // Memory ports.
  logic                       dly_we;
  logic [IDX_W-1:0]           dly_waddr;
  logic [SAMPLE_W-1:0]        dly_wdata;
  logic signed [SAMPLE_W-1:0] dly_rdata;
  logic                       w_we;
  logic [IDX_W-1:0]           w_waddr;
  logic [WEIGHT_W-1:0]        w_wdata;
  logic signed [WEIGHT_W-1:0] w_rdata;

  // Combinational helpers.
  logic                       in_acc;
  logic                       issue;
  logic                       pass_end;
  logic [IDX_W-1:0]           head_next;
  logic [IDX_W-1:0]           dly_addr_next;
  logic signed [MUERR_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_res;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [SH_W-1:0]     acc_sh;
  logic signed [SAMPLE_W-1:0] y_next;
  logic signed [ERR_W-1:0]    err_next;
  logic signed [PROD_W-1:0]   p_rnd;
  logic signed [D_W-1:0]      d_upd;
  logic signed [WS_W-1:0]     w_sum;
  logic signed [WEIGHT_W-1:0] w_new;

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign result.valid  = out_vld;
  assign result.filter_output = out_data;

  assign in_acc   = samples.valid && samples.ready;
  assign issue    = ((state == ST_MAC) || (state == ST_UPD)) &&
                    (issue_cnt != CNT_W'(TAPS));
  assign pass_end = (issue_cnt == CNT_W'(TAPS)) && !s1_vld && !s2_vld;

  // The delay line is a circular buffer: tap 0 lives at head, tap i at head-i.
  assign head_next     = (head == IDX_W'(TAPS - 1)) ? '0 : head + 1'b1;
  assign dly_addr_next = (dly_addr == '0) ? IDX_W'(TAPS - 1) : dly_addr - 1'b1;

  assign dly_we    = (state == ST_CLEAR) || in_acc;
  assign dly_waddr = (state == ST_CLEAR) ? clr_cnt : head_next;
  assign dly_wdata = (state == ST_CLEAR) ? '0 : samples.reference_sample;

  assign w_we    = (state == ST_CLEAR) || ((state == ST_UPD) && s2_vld);
  assign w_waddr = (state == ST_CLEAR) ? clr_cnt : s2_widx;
  assign w_wdata = (state == ST_CLEAR) ? '0 : w_new;

  lmsf_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  lmsf_ram #(.WIDTH(WEIGHT_W), .DEPTH(TAPS)) u_w_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (w_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = MULB_W'(dly_rdata);
    unique case (state)
      ST_MAC: begin
        mul_a = MUERR_W'(w_rdata);
      end
      ST_MUERR: begin
        mul_a = MUERR_W'(err_reg);
        mul_b = $signed({1'b0, step_reg});
      end
      ST_UPD: begin
        mul_a = mu_err;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // Output rounding: round half up at bit 20, then saturate to Q1.15.
  assign acc_rnd = acc + ACC_W'(1 << (OUT_SHIFT - 1));
  assign acc_sh  = acc_rnd[ACC_W-1:OUT_SHIFT];

  always_comb begin
    if (acc_sh > SH_W'(OUT_MAX)) begin
      y_next = SAMPLE_W'(OUT_MAX);
    end else if (acc_sh < SH_W'(OUT_MIN)) begin
      y_next = SAMPLE_W'(OUT_MIN);
    end else begin
      y_next = acc_sh[SAMPLE_W-1:0];
    end
  end

  assign err_next = ERR_W'(primary) - ERR_W'(y_next);

  // Weight update: round half up at bit 26, add, saturate to Q4.20.
  assign p_rnd = product + PROD_W'(1 << (UPD_SHIFT - 1));
  assign d_upd = p_rnd[PROD_W-1:UPD_SHIFT];
  assign w_sum = WS_W'(s2_w) + WS_W'(d_upd);

  always_comb begin
    if (w_sum > WS_W'(W_MAX)) begin
      w_new = WEIGHT_W'(W_MAX);
    end else if (w_sum < WS_W'(W_MIN)) begin
      w_new = WEIGHT_W'(W_MIN);
    end else begin
      w_new = w_sum[WEIGHT_W-1:0];
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step_reg  <= STEP_RESET;
      clr_cnt   <= '0;
      head      <= '0;
      dly_addr  <= '0;
      issue_cnt <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_vld   <= 1'b0;
      out_data  <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        step_reg <= cfg.step_size;
      end

      // In the done state the output register is handled by that state alone.
      if (out_vld && result.ready && (state != ST_DONE)) begin
        out_vld <= 1'b0;
      end

      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
        dly_addr  <= dly_addr_next;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(TAPS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            head      <= head_next;
            dly_addr  <= head_next;
            issue_cnt <= '0;
            state     <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (pass_end) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state <= ST_MUERR;
        end
        ST_MUERR: begin
          state <= ST_MULAT;
        end
        ST_MULAT: begin
          issue_cnt <= '0;
          dly_addr  <= head;
          state     <= ST_UPD;
        end
        ST_UPD: begin
          if (pass_end) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_vld || result.ready) begin
            out_vld  <= 1'b1;
            out_data <= y_reg;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    product <= mul_res;
    s1_widx <= issue_cnt[IDX_W-1:0];
    s2_widx <= s1_widx;
    s2_w    <= w_rdata;
    if (in_acc) begin
      primary <= samples.primary_sample;
      acc     <= '0;
    end else if ((state == ST_MAC) && s2_vld) begin
      acc <= acc + product[ACC_W-1:0];
    end
    if (state == ST_ROUND) begin
      y_reg   <= y_next;
      err_reg <= err_next;
    end
    if (state == ST_MULAT) begin
      mu_err <= product[MUERR_W-1:0];
    end
  end

endmodule

[sv/lmsf_checker.sv]
// Port-level assertions for the LMS adaptive FIR filter and their bind.
`include "assert_macros.svh"

module lmsf_checker import lmsf_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] filter_output
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // The clearing pass keeps the input closed right after reset.
  `LMSF_AST_IMP(a_clear_after_rst, $past(rst), !in_ready && !out_valid, "input open after reset")

  // Each item occupies the shared multiplier, so the block is busy after an accept.
  `LMSF_AST_NXT(a_busy_after_accept, in_acc, !in_ready, "input accepted back to back")

  // A new result only appears as the block returns to idle.
  `LMSF_AST_IMP(a_result_at_idle, $rose(out_valid), in_ready, "result raised while busy")

  // A stalled result beat holds its value.
  `LMSF_AST_NXT(a_result_hold, out_valid && !out_ready,
                out_valid && $stable(filter_output), "stalled result changed")

endmodule

bind lms_adaptive_fir_unit lmsf_checker u_lmsf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .filter_output (result.filter_output)
);

[sim/lms_fir_checker.sv]
// Watches the filter channels, predicts each output beat and compares it with the one seen.
`timescale 1ns / 100ps

module lms_fir_checker
  import lmsf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lmsf_in_if   samples,
  lmsf_out_if  result,
  lmsf_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  logic        [STEP_W-1:0]   mu_q16;
  logic signed [SAMPLE_W-1:0] tap_samples [TAPS_DEF];
  logic signed [WEIGHT_W-1:0] tap_weights [TAPS_DEF];
  logic signed [SAMPLE_W-1:0] expected_outputs [$];

  // Shifts the reference in, forms the FIR output from the old weights, then adapts.
  function automatic logic signed [SAMPLE_W-1:0] filter_and_adapt(
    input logic signed [SAMPLE_W-1:0] primary,
    input logic signed [SAMPLE_W-1:0] reference
  );
    longint acc;
    longint y;
    longint err;
    longint delta;
    longint w_next;
    int     i;
    for (i = TAPS_DEF - 1; i > 0; i--) tap_samples[i] = tap_samples[i-1];
    tap_samples[0] = reference;
    acc = '0;
    for (i = 0; i < TAPS_DEF; i++) begin
      acc += longint'(tap_weights[i]) * longint'(tap_samples[i]);
    end
    // Round half up to Q1.15, then saturate; the error uses the saturated value.
    y = (acc + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (y > OUT_MAX) y = longint'(OUT_MAX);
    if (y < OUT_MIN) y = longint'(OUT_MIN);
    err = longint'(primary) - y;
    for (i = 0; i < TAPS_DEF; i++) begin
      delta = longint'(mu_q16) * err * longint'(tap_samples[i]);
      delta = (delta + (longint'(1) << (UPD_SHIFT - 1))) >>> UPD_SHIFT;
      w_next = longint'(tap_weights[i]) + delta;
      if (w_next > W_MAX) w_next = longint'(W_MAX);
      if (w_next < W_MIN) w_next = longint'(W_MIN);
      tap_weights[i] = w_next[WEIGHT_W-1:0];
    end
    return y[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      mu_q16 = STEP_RESET;
      for (int k = 0; k < TAPS_DEF; k++) begin
        tap_samples[k] = '0;
        tap_weights[k] = '0;
      end
      expected_outputs.delete();
    end else begin
      if (cfg.valid && cfg.ready) mu_q16 = cfg.step_size;
      // Outputs are checked before this edge's input is predicted, so a beat never
      // meets the expectation of an item that was only just taken.
      if (result.valid && result.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: output beat %0d with nothing expected", $time,
                   result.filter_output);
          errors++;
        end else begin
          want = expected_outputs.pop_front();
          if (result.filter_output !== want) begin
            $display("%0t: filter_output mismatch, expected %0d, actual %0d", $time,
                     want, result.filter_output);
            errors++;
          end
        end
      end
      if (samples.valid && samples.ready) begin
        expected_outputs.push_back(filter_and_adapt(samples.primary_sample,
                                                    samples.reference_sample));
      end
    end
    pending = expected_outputs.size();
  end

endmodule

[sim/tb_lms_adaptive_fir_unit.sv]
// Top of the LMS adaptive FIR testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_lms_adaptive_fir_unit import lmsf_pkg::*; ();

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 12;
  // One item keeps the block busy through both tap passes; the tail leaves margin on top.
  localparam int SETTLE_CYCLES  = 2 * TAPS_DEF + 40;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES    = 600;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Percent of cycles in which the sender or the receiver holds back.
  int   src_idle  = 0;
  int   sink_idle = 0;
  logic stall_req = 1'b0;

  int   errors;
  int   pending;

  // Recent reference samples, used to build a primary that is a filtered copy
  // of the reference so that the weights actually converge on something.
  logic signed [SAMPLE_W-1:0] ref_hist [4];

  lmsf_in_if  samples ();
  lmsf_out_if result ();
  lmsf_cfg_if cfg ();

  lms_adaptive_fir_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .result  (result),
    .cfg     (cfg)
  );

  lms_fir_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .result  (result),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random back-pressure, plus a long hold-off when the stimulus asks
  // for one. The request is a one-cycle pulse from the stimulus; the length of
  // the hold-off is counted here.
  initial begin
    int hold_left;
    hold_left    = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        result.ready <= 1'b0;
        hold_left--;
      end else begin
        result.ready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count. The clearing pass after
  // reset is well inside the limit.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (samples.valid && samples.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // All driving tasks are entered at a falling edge and return at a falling edge
  // at which they have assigned nothing yet.

  // Offers one sample pair, with random idle cycles ahead of it. The valid stays
  // high after the beat so that back-to-back items need no low cycle between them.
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] primary,
                           input logic signed [SAMPLE_W-1:0] reference);
    while ($urandom_range(99) < src_idle) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid            <= 1'b1;
    samples.primary_sample   <= primary;
    samples.reference_sample <= reference;
    do @(posedge clk); while (!(samples.valid && samples.ready));
    @(negedge clk);
  endtask

  // Drops valid after the last beat of a burst.
  task automatic stop_samples();
    samples.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted output has come back and the block has had
  // time to finish its last weight update pass.
  task automatic quiesce();
    stop_samples();
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the step size; only ever called while the block is idle.
  task automatic write_step(input logic [STEP_W-1:0] mu);
    cfg.valid     <= 1'b1;
    cfg.step_size <= mu;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rail_value();
    unique case ($urandom_range(4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  // Random items. Half of them follow a simple noise path (primary is a mix of
  // earlier references plus a little noise), which is the case the filter is
  // built for; the rest are full-range noise, rail values and small signals.
  task automatic send_random(input int count);
    logic signed [SAMPLE_W-1:0] p;
    logic signed [SAMPLE_W-1:0] r;
    int                         mode;
    repeat (count) begin
      mode = $urandom_range(99);
      r    = SAMPLE_W'($urandom);
      p    = SAMPLE_W'($urandom);
      if (mode < 50) begin
        p = (ref_hist[1] >>> 1) + (ref_hist[3] >>> 2) +
            SAMPLE_W'($signed($urandom_range(255)) - 128);
      end else if (mode < 75) begin
        // Full-range noise on both fields, already drawn above.
      end else if (mode < 90) begin
        p = rail_value();
        r = rail_value();
      end else begin
        p = SAMPLE_W'($signed($urandom_range(511)) - 256);
        r = SAMPLE_W'($signed($urandom_range(511)) - 256);
      end
      ref_hist[3] = ref_hist[2];
      ref_hist[2] = ref_hist[1];
      ref_hist[1] = ref_hist[0];
      ref_hist[0] = r;
      send_pair(p, r);
    end
  endtask

  initial begin
    samples.valid            = 1'b0;
    samples.primary_sample   = '0;
    samples.reference_sample = '0;
    cfg.valid                = 1'b0;
    cfg.step_size            = '0;
    for (int k = 0; k < 4; k++) ref_hist[k] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. First the field extremes with the reset step size; the
    // block has to come out of its clearing pass before the first beat is taken.
    src_idle  = 33;
    sink_idle = 49;
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'shFFFF, 16'sh0001);

    // With the largest step and full-scale inputs the weights run into their
    // limits within a few items and the output clips high. Flipping the primary
    // then swings the error to its most negative value, which drives the weights
    // to the low limit and the output to its negative clip.
    quiesce();
    write_step(16'hFFFF);
    repeat (8) send_pair(16'sh7FFF, 16'sh7FFF);
    repeat (8) send_pair(16'sh8000, 16'sh7FFF);
    repeat (3) send_pair(16'sh8000, 16'sh8000);

    // Random part, sender idling more lightly than the receiver. A zero step
    // freezes the weights left over from the directed part.
    quiesce();
    write_step(16'h0000);
    send_random(120);
    quiesce();
    write_step(STEP_W'($urandom_range(2, 65534)));
    send_random(150);

    // Idling ratios swapped.
    src_idle  = 49;
    sink_idle = 33;
    quiesce();
    write_step(16'h0001);
    send_random(120);
    quiesce();
    write_step(16'd8192);
    send_random(150);

    // No idling at all: items back to back, output always taken.
    src_idle  = 0;
    sink_idle = 0;
    quiesce();
    write_step(STEP_RESET);
    send_random(150);

    // Long receiver hold-off while the sender keeps offering items: the output
    // register fills, the next result completes behind it and the block stops
    // taking input until the receiver lets go.
    quiesce();
    stall_req <= 1'b1;
    @(negedge clk);
    stall_req <= 1'b0;
    send_random(8);

    quiesce();
    write_step(16'hFFFF);
    send_random(100);

    // Every output has arrived; the tail inside quiesce catches any stray beat.
    quiesce();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[lms_adaptive_fir_unit.f]
+incdir+sv
sv/lmsf_pkg.sv
sv/lmsf_if.sv
sv/lmsf_ram.sv
sv/lms_adaptive_fir_unit.sv
sv/lmsf_checker.sv
sim/lms_fir_checker.sv
sim/tb_lms_adaptive_fir_unit.sv
